>>> rtl/enter_exit_event_joiner_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the enter/exit event joiner
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ENTER_EXIT_EVENT_JOINER_TOP_ASSERT_SVH
`define ENTER_EXIT_EVENT_JOINER_TOP_ASSERT_SVH

// Same-cycle implication.
`define EEJ_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error("joiner check failed");

// Next-cycle implication.
`define EEJ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error("joiner sequencing check failed");

`endif

>>> rtl/eej_pkg.sv
// ----------------------------------------------------------------------------
// eej_pkg
// Types and constants shared by the enter/exit event joiner.
// ----------------------------------------------------------------------------
package eej_pkg;

  localparam int TableEntriesDefault = 64;
  localparam int SweepPeriodDefault  = 256;
  localparam int BodyBitsDefault     = 64;

  localparam logic StatusJoined = 1'b0;
  localparam logic StatusFull   = 1'b1;

  typedef struct packed {
    logic signed [31:0] pid;
    logic signed [31:0] tgid;
    logic [3:0]         syscall_kind;
    logic               is_exit;
    logic [63:0]        enter_args;
    logic signed [63:0] exit_ret;
  } eej_req_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] out_pid;
    logic signed [31:0] out_tgid;
    logic [3:0]         out_kind;
    logic [63:0]        out_args;
    logic signed [63:0] out_ret;
  } eej_res_t;

endpackage

>>> rtl/eej_ram.sv
// ----------------------------------------------------------------------------
// eej_ram
// Single-port-write, single-port-read table memory with a registered read port.
// ----------------------------------------------------------------------------
module eej_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/enter_exit_event_joiner_top.sv
// ----------------------------------------------------------------------------
// enter_exit_event_joiner_top
// Pairs system-call enter and exit items through a table held in memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------
//  request | in        | start_i, busy_o       | req_i  (eej_req_t)
//  result  | out       | res_valid_o (strobe)  | res_o  (eej_res_t)
//
// Each item passes through the idle state, in which the item is accepted, a
// scan that reads every table entry in turn over the single memory read port,
// a drain state that empties the read pipeline, and a finish state that
// inserts or frees the entry and launches the result.
// The aging sweep rides on the same scan, so it costs nothing extra.
// Reset clears valid bits, the event counter and the control state; the
// memory needs no clearing pass since every read is qualified by a valid bit.
// Results show on res_o for one cycle with res_valid_o; there is no stall.
//
module enter_exit_event_joiner_top #(
  parameter int TABLE_ENTRIES = eej_pkg::TableEntriesDefault,
  parameter int SWEEP_PERIOD  = eej_pkg::SweepPeriodDefault,
  parameter int BODY_BITS     = eej_pkg::BodyBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  eej_pkg::eej_req_t req_i,
  output logic             res_valid_o,
  output eej_pkg::eej_res_t res_o
);

  import eej_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = $clog2(SWEEP_PERIOD + 1);
  localparam int AgeW = CntW + 1;
  localparam logic [63:0] BodyMask =
    (BODY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << BODY_BITS) - 64'd1);

  typedef struct packed {
    logic [31:0]            pid;
    logic [31:0]            tgid;
    logic [3:0]             kind;
    logic                   is_exit;
    logic [63:0]            body;
    logic signed [AgeW-1:0] age;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Captured item and per-item scan results.
  eej_req_t               req_q;
  logic                   sweep_q;
  logic signed [AgeW-1:0] new_age_q;
  logic [CntW-1:0]        cnt_q;
  logic [CntW:0]          cnt_inc;

  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] chk_idx_q;
  logic            chk_vld_q;

  logic            opp_found_q, same_found_q, free_found_q;
  logic [IdxW-1:0] opp_idx_q, free_idx_q;
  logic [63:0]     opp_body_q;

  logic [TABLE_ENTRIES-1:0] valid_q;

  eej_res_t res_q;
  logic     res_valid_q;

  // Memory port.
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  entry_t          rdata;
  logic [EntryW-1:0] rdata_raw;

  eej_ram #(
    .Width(EntryW),
    .Depth(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q),
    .rdata_o(rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  logic accept;
  assign accept  = start_i && (state_q == ST_IDLE);
  assign busy_o  = (state_q != ST_IDLE);
  assign cnt_inc = {1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1};

  // Check stage: entry read last cycle is compared against the held item.
  logic chk_valid_bit, aged_out, eff_valid, key_eq, opp_hit, same_hit;
  always_comb begin
    chk_valid_bit = valid_q[chk_idx_q];
    aged_out      = sweep_q && rdata.age[AgeW-1];
    eff_valid     = chk_valid_bit && !aged_out;
    key_eq        = (rdata.pid == req_q.pid) && (rdata.tgid == req_q.tgid) &&
                    (rdata.kind == req_q.syscall_kind);
    opp_hit       = eff_valid && key_eq && (rdata.is_exit != req_q.is_exit);
    same_hit      = eff_valid && key_eq && (rdata.is_exit == req_q.is_exit);
  end

  logic do_insert;
  assign do_insert = (state_q == ST_FINISH) && !opp_found_q && !same_found_q &&
                     free_found_q;

  // Write port: age writeback during the scan, insertion at the end.
  always_comb begin
    we    = 1'b0;
    waddr = chk_idx_q;
    wdata = rdata;
    if (chk_vld_q && chk_valid_bit && sweep_q && !aged_out) begin
      we        = 1'b1;
      wdata.age = rdata.age - AgeW'(SWEEP_PERIOD);
    end else if (do_insert) begin
      we            = 1'b1;
      waddr         = free_idx_q;
      wdata.pid     = req_q.pid;
      wdata.tgid    = req_q.tgid;
      wdata.kind    = req_q.syscall_kind;
      wdata.is_exit = req_q.is_exit;
      wdata.body    = req_q.is_exit ? req_q.exit_ret : (req_q.enter_args & BodyMask);
      wdata.age     = new_age_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == IdxW'(TABLE_ENTRIES - 1)) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      sweep_q      <= 1'b0;
      idx_q        <= '0;
      chk_idx_q    <= '0;
      chk_vld_q    <= 1'b0;
      opp_found_q  <= 1'b0;
      same_found_q <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_vld_q   <= (state_q == ST_SCAN);
      chk_idx_q   <= idx_q;
      res_valid_q <= 1'b0;

      if (accept) begin
        // Advance the event counter; the overflow item runs the sweep.
        if (cnt_inc > (CntW + 1)'(SWEEP_PERIOD)) begin
          sweep_q <= 1'b1;
          cnt_q   <= '0;
        end else begin
          sweep_q <= 1'b0;
          cnt_q   <= cnt_inc[CntW-1:0];
        end
        idx_q        <= '0;
        opp_found_q  <= 1'b0;
        same_found_q <= 1'b0;
        free_found_q <= 1'b0;
      end

      if (state_q == ST_SCAN && idx_q != IdxW'(TABLE_ENTRIES - 1)) begin
        idx_q <= idx_q + IdxW'(1);
      end

      if (chk_vld_q) begin
        if (chk_valid_bit && aged_out) begin
          valid_q[chk_idx_q] <= 1'b0;
        end
        if (opp_hit && !opp_found_q) begin
          opp_found_q <= 1'b1;
        end
        if (same_hit) begin
          same_found_q <= 1'b1;
        end
        if (!eff_valid && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end

      if (state_q == ST_FINISH) begin
        if (opp_found_q) begin
          // Free the partner and emit the joined pair.
          valid_q[opp_idx_q] <= 1'b0;
          res_valid_q        <= 1'b1;
        end else if (same_found_q) begin
          // Drop duplicate key silently.
        end else if (free_found_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end else begin
          // Drop on full table and report it.
          res_valid_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_i;
      new_age_q <= (cnt_inc > (CntW + 1)'(SWEEP_PERIOD)) ? '0
                                                         : AgeW'(cnt_inc);
    end
    if (chk_vld_q && opp_hit && !opp_found_q) begin
      opp_idx_q  <= chk_idx_q;
      opp_body_q <= rdata.body;
    end
    if (chk_vld_q && !eff_valid && !free_found_q) begin
      free_idx_q <= chk_idx_q;
    end
    if (state_q == ST_FINISH) begin
      if (opp_found_q) begin
        res_q.status   <= StatusJoined;
        res_q.out_pid  <= req_q.pid;
        res_q.out_tgid <= req_q.tgid;
        res_q.out_kind <= req_q.syscall_kind;
        res_q.out_args <= req_q.is_exit ? opp_body_q : (req_q.enter_args & BodyMask);
        res_q.out_ret  <= req_q.is_exit ? req_q.exit_ret : opp_body_q;
      end else begin
        res_q.status   <= StatusFull;
        res_q.out_pid  <= '0;
        res_q.out_tgid <= '0;
        res_q.out_kind <= '0;
        res_q.out_args <= '0;
        res_q.out_ret  <= '0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `include "enter_exit_event_joiner_top_assert.svh"

  `EEJ_ASSERT_IMPLIES(a_res_when_idle, res_valid_o, !busy_o)
  `EEJ_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `EEJ_ASSERT_IMPLIES(a_insert_free_slot, do_insert, !valid_q[free_idx_q])
  `EEJ_ASSERT_NEXT(a_res_after_finish, state_q == ST_FINISH && !opp_found_q && !same_found_q && !free_found_q, res_valid_o && res_o.status == StatusFull)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the enter/exit event joiner. A local table model
// predicts joined pairs, duplicate drops, full-table drops and aging sweeps;
// results from the strobe port are checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import eej_pkg::*;

  localparam int Entries = TableEntriesDefault;
  localparam int Period  = SweepPeriodDefault;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  eej_req_t req_i = '0;
  logic     res_valid_o;
  eej_res_t res_o;

  enter_exit_event_joiner_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .res_valid_o, .res_o
  );

  // Clock: invert every half period.
  always #5 clk_i = ~clk_i;

  // Local copy of the pairing table.
  typedef struct packed {
    logic        used;
    logic [31:0] pid;
    logic [31:0] tgid;
    logic [3:0]  kind;
    logic        dir;
    logic [63:0] body;
    int          age;
  } slot_t;

  slot_t    slots [Entries];
  int       evt_count;
  eej_req_t pending_items [$];
  eej_res_t joined_expected [$];
  int       errors, n_sent, n_joined, n_full, n_sweeps;
  logic     quiet;

  // Predict one accepted item and queue the result it causes, if any.
  task automatic join_event(input eej_req_t it);
    eej_res_t r;
    int       hit, dup, fr;
    hit = -1; dup = -1; fr = -1;
    evt_count++;
    if (evt_count > Period) begin
      // Sweep: free negative ages, shift the rest down by one period.
      n_sweeps++;
      for (int i = 0; i < Entries; i++) begin
        if (slots[i].used) begin
          if (slots[i].age < 0) slots[i].used = 1'b0;
          else slots[i].age -= Period;
        end
      end
      evt_count = 0;
    end
    for (int i = Entries - 1; i >= 0; i--) begin
      if (slots[i].used && slots[i].pid == it.pid && slots[i].tgid == it.tgid &&
          slots[i].kind == it.syscall_kind) begin
        if (slots[i].dir != it.is_exit) hit = i;
        else dup = i;
      end
      if (!slots[i].used) fr = i;
    end
    r = '0;
    if (hit >= 0) begin
      slots[hit].used = 1'b0;
      r.status = StatusJoined;
      if (it.is_exit) begin
        r.out_pid  = slots[hit].pid;
        r.out_tgid = slots[hit].tgid;
        r.out_kind = slots[hit].kind;
        r.out_args = slots[hit].body;
        r.out_ret  = it.exit_ret;
      end else begin
        r.out_pid  = it.pid;
        r.out_tgid = it.tgid;
        r.out_kind = it.syscall_kind;
        r.out_args = it.enter_args;
        r.out_ret  = slots[hit].body;
      end
      joined_expected.push_back(r);
    end else if (dup >= 0) begin
      // Drop silently: same key, same direction already held.
    end else if (fr >= 0) begin
      slots[fr] = '{1'b1, it.pid, it.tgid, it.syscall_kind, it.is_exit,
                    it.is_exit ? it.exit_ret : it.enter_args, evt_count};
    end else begin
      r.status = StatusFull;
      joined_expected.push_back(r);
    end
  endtask

  // Driver: offer the next item unless idling; advance on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        join_event(req_i);
        n_sent++;
        void'(pending_items.pop_front());
      end
      if (!start_i || !busy_o) begin
        if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 35)) begin
          start_i <= 1'b1;
          req_i   <= pending_items[0];
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (joined_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, res_o);
      end else begin
        eej_res_t e;
        e = joined_expected.pop_front();
        if (e.status == StatusFull) n_full++;
        else n_joined++;
        if (res_o.status !== e.status || res_o.out_pid !== e.out_pid ||
            res_o.out_tgid !== e.out_tgid || res_o.out_kind !== e.out_kind ||
            res_o.out_args !== e.out_args || res_o.out_ret !== e.out_ret) begin
          errors++;
          $display("%0t: result mismatch, expected %h, actual %h", $time, e, res_o);
        end
      end
    end
  end

  function automatic eej_req_t make_event(logic [31:0] p, logic [31:0] t, logic [3:0] k,
                                          logic d);
    eej_req_t it;
    it.pid = p; it.tgid = t; it.syscall_kind = k; it.is_exit = d;
    it.enter_args = {$urandom, $urandom};
    it.exit_ret   = {$urandom, $urandom};
    return it;
  endfunction

  initial begin
    eej_req_t it;
    logic [31:0] pids [8];
    errors = 0; n_sent = 0; n_joined = 0; n_full = 0; n_sweeps = 0;
    evt_count = 0; quiet = 1'b0;
    foreach (slots[i]) slots[i] = '0;
    foreach (pids[i]) pids[i] = $urandom;

    // Directed: field extremes, both join orders, duplicate drop.
    it = make_event(32'h8000_0000, 32'h7fff_ffff, 4'hf, 1'b0);
    it.enter_args = '1;
    pending_items.push_back(it);
    it.is_exit = 1'b1; it.exit_ret = 64'h8000_0000_0000_0000;
    pending_items.push_back(it);
    it = make_event(32'h0, 32'hffff_ffff, 4'h0, 1'b1);
    it.exit_ret = '1;
    pending_items.push_back(it);
    pending_items.push_back(it);
    it.is_exit = 1'b0; it.enter_args = '0;
    pending_items.push_back(it);
    it = make_event(32'h7fff_ffff, 32'h0, 4'h5, 1'b0);
    pending_items.push_back(it);
    pending_items.push_back(it);
    it.is_exit = 1'b1;
    pending_items.push_back(it);
    // Fill the table past capacity with unmatched enters, then drain with exits.
    for (int i = 0; i < Entries + 3; i++)
      pending_items.push_back(make_event(i, 32'h1234, 4'h3, 1'b0));
    for (int i = 0; i < Entries + 3; i++)
      pending_items.push_back(make_event(i, 32'h1234, 4'h3, 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random: mostly matched enter/exit traffic on a small key space so
    // that pairs meet, mixed with fully random noise items.
    for (int n = 0; n < 1700; n++) begin
      if ($urandom_range(9) == 0) begin
        it = make_event($urandom, $urandom, 4'($urandom), 1'($urandom));
      end else begin
        it = make_event(pids[$urandom_range(7)], $urandom_range(3),
                        4'($urandom_range(15)), 1'($urandom_range(1)));
      end
      pending_items.push_back(it);
      // Hold back the feed a bit so the idling pattern can vary over time.
      if (n % 100 == 0) begin
        wait (pending_items.size() < 40);
        quiet = (n >= 600 && n < 900);
      end
    end

    wait (pending_items.size() == 0 && !start_i);
    wait (joined_expected.size() == 0);
    repeat (2 * (Entries + 3)) @(posedge clk_i);
    $display("Sent %0d items: %0d joined pairs, %0d table-full drops, %0d aging sweeps.",
             n_sent, n_joined, n_full, n_sweeps);
    if (errors == 0) begin
      $display("enter_exit_event_joiner_top test passed");
    end else begin
      $display("enter_exit_event_joiner_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("enter_exit_event_joiner_top test failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/eej_pkg.sv
rtl/eej_ram.sv
rtl/enter_exit_event_joiner_top.sv
tb/tb_top.sv
